@@ sv/char_lcd_nibble_sequencer_top_defines.svh @@
// ----------------------------------------------------------------------------
// char_lcd_nibble_sequencer_top_defines
// assertion macros shared by the lcd nibble sequencer queue and pin sequencer modules
// ----------------------------------------------------------------------------
`ifndef CHAR_LCD_NIBBLE_SEQUENCER_TOP_DEFINES_SVH
`define CHAR_LCD_NIBBLE_SEQUENCER_TOP_DEFINES_SVH

// property must hold at every rising clock edge out of reset
`define LCDNS_ASSERT(name, prop, msg) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// condition must never be seen out of reset
`define LCDNS_ASSERT_NEVER(name, cond, msg) \
    name: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) else $error(msg);

`endif

@@ sv/lcdns_pkg.sv @@
// ----------------------------------------------------------------------------
// lcdns_pkg
// types, command codes and tables for the lcd nibble sequencer
// ----------------------------------------------------------------------------
`default_nettype none

package lcdns_pkg;

    typedef enum logic [3:0] {
        REQ_CMD         = 4'd0,
        REQ_MSG         = 4'd1,
        REQ_CURSOR      = 4'd2,
        REQ_DISPLAY     = 4'd3,
        REQ_CURSOR_SHOW = 4'd4,
        REQ_BLINK       = 4'd5,
        REQ_SHIFT       = 4'd6,
        REQ_LTR         = 4'd7,
        REQ_AUTOSCROLL  = 4'd8,
        REQ_CLEAR       = 4'd9,
        REQ_HOME        = 4'd10,
        REQ_INIT        = 4'd11
    } req_t;

    // extra hold after the last pin state of a byte
    typedef enum logic [1:0] {
        EXT_NONE  = 2'd0,
        EXT_CLEAR = 2'd1,
        EXT_HOME  = 2'd2
    } ext_t;

    typedef enum logic [2:0] {
        PH_HI_SETUP  = 3'd0,
        PH_HI_STROBE = 3'd1,
        PH_HI_HOLD   = 3'd2,
        PH_LO_SETUP  = 3'd3,
        PH_LO_STROBE = 3'd4,
        PH_LO_HOLD   = 3'd5
    } phase_t;

    typedef struct packed {
        logic [7:0] byte_val;
        logic       rs;
        ext_t       ext;
        logic       last;
    } q_entry_t;

    localparam int MAX_ROWS = 4;

    localparam logic [5:0] COLUMN_RESET = 6'd20;
    localparam logic [5:0] COLUMN_MAX   = 6'd40;
    localparam logic [2:0] LINE_RESET   = 3'd4;
    localparam logic [7:0] CHAR_NEWLINE = 8'h0A;

    localparam logic [7:0] CMD_INIT_A    = 8'h33;
    localparam logic [7:0] CMD_INIT_B    = 8'h32;
    localparam logic [7:0] CMD_SET_ADDR  = 8'h80;
    localparam logic [7:0] CMD_DISP_CTRL = 8'h08;
    localparam logic [7:0] CMD_ENTRY     = 8'h04;
    localparam logic [7:0] CMD_CLEAR     = 8'h01;
    localparam logic [7:0] CMD_HOME      = 8'h02;
    localparam logic [7:0] CMD_SHIFT_L   = 8'h18;
    localparam logic [7:0] CMD_SHIFT_R   = 8'h1C;
    localparam logic [7:0] CMD_FUNC_SET  = 8'h28;

    localparam logic [2:0] CTRL_DISPLAY = 3'b100;
    localparam logic [2:0] CTRL_CURSOR  = 3'b010;
    localparam logic [2:0] CTRL_BLINK   = 3'b001;
    localparam logic [2:0] CTRL_RESET   = 3'b100;
    localparam logic [1:0] ENTRY_LEFT   = 2'b10;
    localparam logic [1:0] ENTRY_SHIFT  = 2'b01;
    localparam logic [1:0] ENTRY_RESET  = 2'b10;

    localparam logic [11:0] HOLD_BASE  = 12'd1;
    localparam logic [11:0] HOLD_PRE   = 12'd1001;
    localparam logic [11:0] HOLD_CLEAR = 12'd2001;
    localparam logic [11:0] HOLD_HOME  = 12'd3001;

    localparam logic [2:0] INIT_LAST = 3'd5;

    function automatic logic [6:0] row_base(input logic [1:0] row);
        logic [6:0] base;
        case (row)
            2'd0:    base = 7'h00;
            2'd1:    base = 7'h40;
            2'd2:    base = 7'h14;
            default: base = 7'h54;
        endcase
        return base;
    endfunction

    // start-up byte sequence
    function automatic q_entry_t init_entry(input logic [2:0] idx);
        q_entry_t e;
        e.rs   = 1'b0;
        e.ext  = EXT_NONE;
        e.last = 1'b0;
        case (idx)
            3'd0:    e.byte_val = CMD_INIT_A;
            3'd1:    e.byte_val = CMD_INIT_B;
            3'd2:    e.byte_val = CMD_DISP_CTRL | {5'd0, CTRL_RESET};
            3'd3:    e.byte_val = CMD_FUNC_SET;
            3'd4:    e.byte_val = CMD_ENTRY | {6'd0, ENTRY_RESET};
            default:
            begin
                e.byte_val = CMD_CLEAR;
                e.ext      = EXT_CLEAR;
                e.last     = 1'b1;
            end
        endcase
        return e;
    endfunction

endpackage

`default_nettype wire

@@ sv/char_lcd_nibble_sequencer_top.sv @@
// ----------------------------------------------------------------------------
// char_lcd_nibble_sequencer_top
// hd44780-style 4-bit lcd request sequencer: requests in, pin states out
//
//   channel | dir | handshake          | payload
//   s_*     | in  | s_tvalid/s_tready  | s_tuser req_type, s_tdata request fields
//   m_*     | out | m_tvalid/m_tready  | m_tuser reg_select, m_tdata pins, m_tlast
//   cfg_*   | in  | cfg_wen            | cfg_index register, cfg_data value
//
// each byte gives six beats, one per cycle from the pin sequencer while
// m_tready is high; the start-up request gives six bytes and an ignored code
// none; with the queue empty the first beat goes from the queue slot through
// the current-byte register into the output registers
// the byte queue (QUEUE_DEPTH entries) lets requests be taken while bytes play
// out; requests stall only while the queue is full or start-up bytes are queued
// reset is asynchronous and restores mode flags, line counter and registers
// ----------------------------------------------------------------------------
`default_nettype none

module char_lcd_nibble_sequencer_top #(
    parameter int QUEUE_DEPTH = 4
) (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        cfg_wen,
    input  wire logic        cfg_index,
    input  wire logic [5:0]  cfg_data,
    input  wire logic        s_tvalid,
    output logic             s_tready,
    // byte_value [7:0], column [13:8], row_index [16:14], flag_on [17],
    // message_start [18], zero [23:19]
    input  wire logic [23:0] s_tdata,
    // req_type [3:0]
    input  wire logic [3:0]  s_tuser,
    output logic             m_tvalid,
    input  wire logic        m_tready,
    // data_nibble [3:0], enable_pin [4], hold_us [16:5], zero [23:17]
    output logic [23:0]      m_tdata,
    // reg_select [0]
    output logic             m_tuser,
    output logic             m_tlast
);

    lcdns_pkg::q_entry_t q_wr_entry;
    lcdns_pkg::q_entry_t q_rd_entry;
    logic q_push;
    logic q_full;
    logic q_pop;
    logic q_empty;

    lcdns_front u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg_wen    (cfg_wen),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data),
        .s_tvalid   (s_tvalid),
        .s_tready   (s_tready),
        .s_tdata    (s_tdata),
        .s_tuser    (s_tuser),
        .q_push     (q_push),
        .q_wr_entry (q_wr_entry),
        .q_full     (q_full)
    );

    lcdns_fifo #(
        .DEPTH (QUEUE_DEPTH)
    ) u_fifo (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (q_push),
        .wr_entry (q_wr_entry),
        .full     (q_full),
        .pop      (q_pop),
        .rd_entry (q_rd_entry),
        .empty    (q_empty)
    );

    lcdns_back u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .q_rd_entry (q_rd_entry),
        .q_empty    (q_empty),
        .q_pop      (q_pop),
        .m_tvalid   (m_tvalid),
        .m_tready   (m_tready),
        .m_tdata    (m_tdata),
        .m_tuser    (m_tuser),
        .m_tlast    (m_tlast)
    );

endmodule

`default_nettype wire

@@ sv/lcdns_front.sv @@
// ----------------------------------------------------------------------------
// lcdns_front
// takes requests, keeps the lcd mode flags and turns requests into bytes
// ----------------------------------------------------------------------------
`default_nettype none

module lcdns_front (
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire logic                 cfg_wen,
    input  wire logic                 cfg_index,
    input  wire logic [5:0]           cfg_data,
    input  wire logic                 s_tvalid,
    output logic                      s_tready,
    input  wire logic [23:0]          s_tdata,
    input  wire logic [3:0]           s_tuser,
    output logic                      q_push,
    output lcdns_pkg::q_entry_t       q_wr_entry,
    input  wire logic                 q_full
);

    logic [5:0] column_count_reg, column_count_next;
    logic [2:0] line_count_reg, line_count_next;
    logic [2:0] control_reg, control_next;
    logic [1:0] entry_reg, entry_next;
    logic [2:0] msg_line_reg, msg_line_next;
    logic [2:0] init_cnt_reg, init_cnt_next;

    lcdns_pkg::req_t req;
    logic [7:0] byte_value;
    logic [5:0] column;
    logic [2:0] row_index;
    logic       flag_on;
    logic       message_start;
    logic       accept;

    logic [2:0] ml_base;
    logic [2:0] ml_inc;
    logic [5:0] cols_eff;
    logic [5:0] nl_col;
    logic [5:0] col_sel;
    logic [2:0] row_sel;
    logic [2:0] lines_eff;
    logic [2:0] row_a;
    logic [2:0] row_b;
    logic [6:0] addr;
    logic [7:0] addr_byte;
    logic [2:0] ctrl_bit;
    logic [2:0] ctrl_new;

    assign req           = lcdns_pkg::req_t'(s_tuser);
    assign byte_value    = s_tdata[7:0];
    assign column        = s_tdata[13:8];
    assign row_index     = s_tdata[16:14];
    assign flag_on       = s_tdata[17];
    assign message_start = s_tdata[18];

    assign s_tready = (init_cnt_reg == 3'd0) && !q_full;
    assign accept   = s_tvalid && s_tready;

    // newline line counter and column
    always_comb
    begin
        ml_base = message_start ? 3'd0 : msg_line_reg;
        ml_inc  = (ml_base == 3'd7) ? 3'd7 : ml_base + 3'd1;
        if (column_count_reg == 6'd0)
            cols_eff = 6'd1;
        else if (column_count_reg > lcdns_pkg::COLUMN_MAX)
            cols_eff = lcdns_pkg::COLUMN_MAX;
        else
            cols_eff = column_count_reg;
        nl_col = (entry_reg[1]) ? 6'd0 : cols_eff - 6'd1;
    end

    // set-address byte with row clamping
    always_comb
    begin
        col_sel   = (req == lcdns_pkg::REQ_MSG) ? nl_col : column;
        row_sel   = (req == lcdns_pkg::REQ_MSG) ? ml_inc : row_index;
        lines_eff = (line_count_reg == 3'd0) ? 3'd1 : line_count_reg;
        row_a     = (row_sel >= lines_eff) ? lines_eff - 3'd1 : row_sel;
        row_b     = (row_a > 3'(lcdns_pkg::MAX_ROWS - 1)) ?
                    3'(lcdns_pkg::MAX_ROWS - 1) : row_a;
        addr      = {1'b0, col_sel} + lcdns_pkg::row_base(row_b[1:0]);
        addr_byte = lcdns_pkg::CMD_SET_ADDR | {1'b0, addr};
    end

    always_comb
    begin
        case (req)
            lcdns_pkg::REQ_DISPLAY:     ctrl_bit = lcdns_pkg::CTRL_DISPLAY;
            lcdns_pkg::REQ_CURSOR_SHOW: ctrl_bit = lcdns_pkg::CTRL_CURSOR;
            default:                    ctrl_bit = lcdns_pkg::CTRL_BLINK;
        endcase
        ctrl_new = flag_on ? (control_reg | ctrl_bit) : (control_reg & ~ctrl_bit);
    end

    always_comb
    begin
        column_count_next = column_count_reg;
        line_count_next   = line_count_reg;
        control_next      = control_reg;
        entry_next        = entry_reg;
        msg_line_next     = msg_line_reg;
        init_cnt_next     = init_cnt_reg;
        q_push            = 1'b0;
        q_wr_entry.byte_val = 8'd0;
        q_wr_entry.rs       = 1'b0;
        q_wr_entry.ext      = lcdns_pkg::EXT_NONE;
        q_wr_entry.last     = 1'b1;

        if (cfg_wen)
        begin
            if (cfg_index == 1'b0)
                column_count_next = cfg_data;
            else
                line_count_next = cfg_data[2:0];
        end

        if (init_cnt_reg != 3'd0)
        begin
            // rest of the start-up bytes, one per free queue slot
            q_wr_entry = lcdns_pkg::init_entry(init_cnt_reg);
            if (!q_full)
            begin
                q_push        = 1'b1;
                init_cnt_next = (init_cnt_reg == lcdns_pkg::INIT_LAST) ?
                                3'd0 : init_cnt_reg + 3'd1;
            end
        end
        else if (accept)
        begin
            case (req)
                lcdns_pkg::REQ_CMD:
                begin
                    q_push = 1'b1;
                    q_wr_entry.byte_val = byte_value;
                end
                lcdns_pkg::REQ_MSG:
                begin
                    q_push = 1'b1;
                    if (byte_value == lcdns_pkg::CHAR_NEWLINE)
                    begin
                        msg_line_next       = ml_inc;
                        q_wr_entry.byte_val = addr_byte;
                    end
                    else
                    begin
                        msg_line_next       = ml_base;
                        q_wr_entry.byte_val = byte_value;
                        q_wr_entry.rs       = 1'b1;
                    end
                end
                lcdns_pkg::REQ_CURSOR:
                begin
                    q_push = 1'b1;
                    q_wr_entry.byte_val = addr_byte;
                end
                lcdns_pkg::REQ_DISPLAY,
                lcdns_pkg::REQ_CURSOR_SHOW,
                lcdns_pkg::REQ_BLINK:
                begin
                    q_push       = 1'b1;
                    control_next = ctrl_new;
                    q_wr_entry.byte_val = lcdns_pkg::CMD_DISP_CTRL | {5'd0, ctrl_new};
                end
                lcdns_pkg::REQ_SHIFT:
                begin
                    q_push = 1'b1;
                    q_wr_entry.byte_val = flag_on ? lcdns_pkg::CMD_SHIFT_R :
                                                    lcdns_pkg::CMD_SHIFT_L;
                end
                lcdns_pkg::REQ_LTR:
                begin
                    q_push     = 1'b1;
                    entry_next = entry_reg | lcdns_pkg::ENTRY_LEFT;
                    q_wr_entry.byte_val = lcdns_pkg::CMD_ENTRY |
                                          {6'd0, entry_reg | lcdns_pkg::ENTRY_LEFT};
                end
                lcdns_pkg::REQ_AUTOSCROLL:
                begin
                    q_push     = 1'b1;
                    entry_next = {entry_reg[1], flag_on};
                    q_wr_entry.byte_val = lcdns_pkg::CMD_ENTRY |
                                          {6'd0, entry_reg[1], flag_on};
                end
                lcdns_pkg::REQ_CLEAR:
                begin
                    q_push = 1'b1;
                    q_wr_entry.byte_val = lcdns_pkg::CMD_CLEAR;
                    q_wr_entry.ext      = lcdns_pkg::EXT_CLEAR;
                end
                lcdns_pkg::REQ_HOME:
                begin
                    q_push = 1'b1;
                    q_wr_entry.byte_val = lcdns_pkg::CMD_HOME;
                    q_wr_entry.ext      = lcdns_pkg::EXT_HOME;
                end
                lcdns_pkg::REQ_INIT:
                begin
                    q_push        = 1'b1;
                    q_wr_entry    = lcdns_pkg::init_entry(3'd0);
                    control_next  = lcdns_pkg::CTRL_RESET;
                    entry_next    = lcdns_pkg::ENTRY_RESET;
                    init_cnt_next = 3'd1;
                end
                default:
                begin
                    q_push = 1'b0;
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            column_count_reg <= lcdns_pkg::COLUMN_RESET;
            line_count_reg   <= lcdns_pkg::LINE_RESET;
            control_reg      <= lcdns_pkg::CTRL_RESET;
            entry_reg        <= lcdns_pkg::ENTRY_RESET;
            msg_line_reg     <= 3'd0;
            init_cnt_reg     <= 3'd0;
        end
        else
        begin
            column_count_reg <= column_count_next;
            line_count_reg   <= line_count_next;
            control_reg      <= control_next;
            entry_reg        <= entry_next;
            msg_line_reg     <= msg_line_next;
            init_cnt_reg     <= init_cnt_next;
        end
    end

endmodule

`default_nettype wire

@@ sv/lcdns_fifo.sv @@
// ----------------------------------------------------------------------------
// lcdns_fifo
// short byte queue between the request front end and the pin sequencer
// ----------------------------------------------------------------------------
`default_nettype none

`include "char_lcd_nibble_sequencer_top_defines.svh"

module lcdns_fifo #(
    parameter int DEPTH = 4
) (
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire logic                 push,
    input  wire lcdns_pkg::q_entry_t  wr_entry,
    output logic                      full,
    input  wire logic                 pop,
    output lcdns_pkg::q_entry_t       rd_entry,
    output logic                      empty
);

    localparam int PTR_W = $clog2(DEPTH);
    localparam int CNT_W = $clog2(DEPTH + 1);

    lcdns_pkg::q_entry_t slot_reg [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] count_reg, count_next;

    assign full     = (count_reg == CNT_W'(DEPTH));
    assign empty    = (count_reg == '0);
    assign rd_entry = slot_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
            wr_ptr_next = (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + PTR_W'(1);
        if (pop)
            rd_ptr_next = (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + PTR_W'(1);
        if (push && !pop)
            count_next = count_reg + CNT_W'(1);
        else if (pop && !push)
            count_next = count_reg - CNT_W'(1);
    end

    always_ff @(posedge clk)
    begin
        if (push)
            slot_reg[wr_ptr_reg] <= wr_entry;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    `LCDNS_ASSERT_NEVER(a_no_overflow, push && full, "byte pushed into a full queue")
    `LCDNS_ASSERT_NEVER(a_no_underflow, pop && empty, "byte popped from an empty queue")

endmodule

`default_nettype wire

@@ sv/lcdns_back.sv @@
// ----------------------------------------------------------------------------
// lcdns_back
// plays each queued byte out as six pin states on the output stream
// ----------------------------------------------------------------------------
`default_nettype none

`include "char_lcd_nibble_sequencer_top_defines.svh"

module lcdns_back (
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire lcdns_pkg::q_entry_t  q_rd_entry,
    input  wire logic                 q_empty,
    output logic                      q_pop,
    output logic                      m_tvalid,
    input  wire logic                 m_tready,
    output logic [23:0]               m_tdata,
    output logic                      m_tuser,
    output logic                      m_tlast
);

    logic                cur_valid_reg, cur_valid_next;
    lcdns_pkg::q_entry_t cur_reg, cur_next;
    lcdns_pkg::phase_t   phase_reg, phase_next;
    logic                m_tvalid_reg, m_tvalid_next;

    logic [3:0]  nib_reg;
    logic        en_reg;
    logic [11:0] hold_reg;
    logic        rs_reg;
    logic        last_reg;

    logic        load;
    logic        ending;
    logic [3:0]  ph_nib;
    logic        ph_en;
    logic [11:0] ph_hold;
    logic        ph_last;

    assign load   = cur_valid_reg && (!m_tvalid_reg || m_tready);
    assign ending = load && (phase_reg == lcdns_pkg::PH_LO_HOLD);
    assign q_pop  = !q_empty && (!cur_valid_reg || ending);

    always_comb
    begin
        cur_valid_next = cur_valid_reg;
        cur_next       = cur_reg;
        if (q_pop)
        begin
            cur_valid_next = 1'b1;
            cur_next       = q_rd_entry;
        end
        else if (ending)
            cur_valid_next = 1'b0;
        m_tvalid_next = load ? 1'b1 : (m_tready ? 1'b0 : m_tvalid_reg);
    end

    // next phase
    always_comb
    begin
        phase_next = phase_reg;
        if (q_pop)
            phase_next = lcdns_pkg::PH_HI_SETUP;
        else if (load)
        begin
            case (phase_reg)
                lcdns_pkg::PH_HI_SETUP:  phase_next = lcdns_pkg::PH_HI_STROBE;
                lcdns_pkg::PH_HI_STROBE: phase_next = lcdns_pkg::PH_HI_HOLD;
                lcdns_pkg::PH_HI_HOLD:   phase_next = lcdns_pkg::PH_LO_SETUP;
                lcdns_pkg::PH_LO_SETUP:  phase_next = lcdns_pkg::PH_LO_STROBE;
                lcdns_pkg::PH_LO_STROBE: phase_next = lcdns_pkg::PH_LO_HOLD;
                default:                 phase_next = lcdns_pkg::PH_HI_SETUP;
            endcase
        end
    end

    // pin state of the current phase
    always_comb
    begin
        ph_nib  = cur_reg.byte_val[7:4];
        ph_en   = 1'b0;
        ph_hold = lcdns_pkg::HOLD_BASE;
        ph_last = 1'b0;
        case (phase_reg)
            lcdns_pkg::PH_HI_SETUP:  ph_hold = lcdns_pkg::HOLD_PRE;
            lcdns_pkg::PH_HI_STROBE: ph_en   = 1'b1;
            lcdns_pkg::PH_HI_HOLD:   ph_en   = 1'b0;
            lcdns_pkg::PH_LO_SETUP:  ph_nib  = cur_reg.byte_val[3:0];
            lcdns_pkg::PH_LO_STROBE:
            begin
                ph_nib = cur_reg.byte_val[3:0];
                ph_en  = 1'b1;
            end
            lcdns_pkg::PH_LO_HOLD:
            begin
                ph_nib  = cur_reg.byte_val[3:0];
                ph_last = cur_reg.last;
                case (cur_reg.ext)
                    lcdns_pkg::EXT_CLEAR: ph_hold = lcdns_pkg::HOLD_CLEAR;
                    lcdns_pkg::EXT_HOME:  ph_hold = lcdns_pkg::HOLD_HOME;
                    default:              ph_hold = lcdns_pkg::HOLD_BASE;
                endcase
            end
            default: ph_en = 1'b0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cur_valid_reg <= 1'b0;
            phase_reg     <= lcdns_pkg::PH_HI_SETUP;
            m_tvalid_reg  <= 1'b0;
        end
        else
        begin
            cur_valid_reg <= cur_valid_next;
            phase_reg     <= phase_next;
            m_tvalid_reg  <= m_tvalid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        cur_reg <= cur_next;
        if (load)
        begin
            nib_reg  <= ph_nib;
            en_reg   <= ph_en;
            hold_reg <= ph_hold;
            rs_reg   <= cur_reg.rs;
            last_reg <= ph_last;
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = {7'd0, hold_reg, en_reg, nib_reg};
    assign m_tuser  = rs_reg;
    assign m_tlast  = last_reg;

    `LCDNS_ASSERT(a_phase_waits, (cur_valid_reg && !load && !q_pop) |=> $stable(phase_reg), "phase moved without a beat")
    `LCDNS_ASSERT(a_long_hold_strobe_low, (m_tvalid_reg && hold_reg > 12'd1) |-> !en_reg, "long hold with enable high")
    `LCDNS_ASSERT(a_last_on_hold_phase, (m_tvalid_reg && last_reg) |-> (!en_reg && hold_reg != lcdns_pkg::HOLD_PRE), "tlast on a setup or strobe beat")

endmodule

`default_nettype wire

@@ verif/char_lcd_nibble_sequencer_checker.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// char_lcd_nibble_sequencer_checker
// watches the request, pin and register ports of the lcd sequencer, predicts
// the pin beats of every accepted request and compares them in arrival order
// ----------------------------------------------------------------------------

module char_lcd_nibble_sequencer_checker #(
    parameter logic COLUMN_REG = 1'b0,
    parameter logic LINE_REG   = 1'b1
) (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        cfg_wen,
    input  wire logic        cfg_index,
    input  wire logic [5:0]  cfg_data,
    input  wire logic        s_tvalid,
    input  wire logic        s_tready,
    // byte_value [7:0], column [13:8], row_index [16:14], flag_on [17],
    // message_start [18], zero [23:19]
    input  wire logic [23:0] s_tdata,
    // req_type [3:0]
    input  wire logic [3:0]  s_tuser,
    input  wire logic        m_tvalid,
    input  wire logic        m_tready,
    // data_nibble [3:0], enable_pin [4], hold_us [16:5], zero [23:17]
    input  wire logic [23:0] m_tdata,
    // reg_select [0]
    input  wire logic        m_tuser,
    input  wire logic        m_tlast,
    output int               error_count,
    output int               pending
);

    import lcdns_pkg::*;

    localparam int         REPORT_LIMIT = 10;
    localparam logic [2:0] LINE_SATURATE = 3'd7;

    typedef struct packed {
        logic        rs;
        logic [3:0]  nibble;
        logic        strobe;
        logic [11:0] hold;
        logic        last;
    } pin_beat_t;

    pin_beat_t  pin_beats_due[$];
    logic [5:0] column_count = COLUMN_RESET;
    logic [2:0] line_count   = LINE_RESET;
    logic [2:0] display_ctrl = CTRL_RESET;
    logic [1:0] entry_mode   = ENTRY_RESET;
    logic [2:0] message_row  = 3'd0;
    int         reported     = 0;

    initial
    begin
        error_count = 0;
        pending     = 0;
    end

    // one byte is six beats: high nibble then low nibble, strobe low-high-low
    function automatic void queue_byte(input logic [7:0] value, input logic rs,
                                       input logic [11:0] final_hold);
        pin_beat_t beat;
        beat.rs     = rs;
        beat.last   = 1'b0;
        beat.nibble = value[7:4];
        beat.strobe = 1'b0;
        beat.hold   = HOLD_PRE;
        pin_beats_due.push_back(beat);
        beat.strobe = 1'b1;
        beat.hold   = HOLD_BASE;
        pin_beats_due.push_back(beat);
        beat.strobe = 1'b0;
        pin_beats_due.push_back(beat);
        beat.nibble = value[3:0];
        pin_beats_due.push_back(beat);
        beat.strobe = 1'b1;
        pin_beats_due.push_back(beat);
        beat.strobe = 1'b0;
        beat.hold   = final_hold;
        pin_beats_due.push_back(beat);
    endfunction

    function automatic void queue_set_address(input logic [5:0] col, input logic [2:0] row);
        logic [2:0] rows_used;
        logic [2:0] r;
        logic [6:0] offset;
        logic [6:0] addr;
        rows_used = (line_count == 3'd0) ? 3'd1 : line_count;
        r = (row >= rows_used) ? rows_used - 3'd1 : row;
        if (int'(r) > MAX_ROWS - 1)
            r = 3'(MAX_ROWS - 1);
        case (r[1:0])
            2'd0:    offset = 7'h00;
            2'd1:    offset = 7'h40;
            2'd2:    offset = 7'h14;
            default: offset = 7'h54;
        endcase
        // address wraps within seven bits
        addr = {1'b0, col} + offset;
        queue_byte(CMD_SET_ADDR | {1'b0, addr}, 1'b0, HOLD_BASE);
    endfunction

    function automatic void predict_request(input logic [3:0] req, input logic [23:0] fields);
        logic [7:0] value;
        logic [5:0] col;
        logic [2:0] row;
        logic       flag;
        logic       start;
        logic [2:0] ctrl_bit;
        logic [5:0] cols;
        int         first;
        pin_beat_t  tail;
        value = fields[7:0];
        col   = fields[13:8];
        row   = fields[16:14];
        flag  = fields[17];
        start = fields[18];
        first = pin_beats_due.size();
        case (req)
            REQ_CMD:
                queue_byte(value, 1'b0, HOLD_BASE);
            REQ_MSG:
            begin
                if (start)
                    message_row = 3'd0;
                if (value == CHAR_NEWLINE)
                begin
                    cols = (column_count == 6'd0) ? 6'd1 : column_count;
                    if (cols > COLUMN_MAX)
                        cols = COLUMN_MAX;
                    if (message_row < LINE_SATURATE)
                        message_row = message_row + 3'd1;
                    queue_set_address(((entry_mode & ENTRY_LEFT) != 2'd0) ? 6'd0 : cols - 6'd1,
                                      message_row);
                end
                else
                    queue_byte(value, 1'b1, HOLD_BASE);
            end
            REQ_CURSOR:
                queue_set_address(col, row);
            REQ_DISPLAY, REQ_CURSOR_SHOW, REQ_BLINK:
            begin
                ctrl_bit = (req == REQ_DISPLAY) ? CTRL_DISPLAY :
                           (req == REQ_CURSOR_SHOW) ? CTRL_CURSOR : CTRL_BLINK;
                display_ctrl = flag ? (display_ctrl | ctrl_bit) : (display_ctrl & ~ctrl_bit);
                queue_byte(CMD_DISP_CTRL | {5'd0, display_ctrl}, 1'b0, HOLD_BASE);
            end
            REQ_SHIFT:
                queue_byte(flag ? CMD_SHIFT_R : CMD_SHIFT_L, 1'b0, HOLD_BASE);
            REQ_LTR:
            begin
                entry_mode = entry_mode | ENTRY_LEFT;
                queue_byte(CMD_ENTRY | {6'd0, entry_mode}, 1'b0, HOLD_BASE);
            end
            REQ_AUTOSCROLL:
            begin
                entry_mode = flag ? (entry_mode | ENTRY_SHIFT) : (entry_mode & ENTRY_LEFT);
                queue_byte(CMD_ENTRY | {6'd0, entry_mode}, 1'b0, HOLD_BASE);
            end
            REQ_CLEAR:
                queue_byte(CMD_CLEAR, 1'b0, HOLD_CLEAR);
            REQ_HOME:
                queue_byte(CMD_HOME, 1'b0, HOLD_HOME);
            REQ_INIT:
            begin
                queue_byte(CMD_INIT_A, 1'b0, HOLD_BASE);
                queue_byte(CMD_INIT_B, 1'b0, HOLD_BASE);
                display_ctrl = CTRL_RESET;
                entry_mode   = ENTRY_RESET;
                queue_byte(CMD_DISP_CTRL | {5'd0, display_ctrl}, 1'b0, HOLD_BASE);
                queue_byte(CMD_FUNC_SET, 1'b0, HOLD_BASE);
                queue_byte(CMD_ENTRY | {6'd0, entry_mode}, 1'b0, HOLD_BASE);
                queue_byte(CMD_CLEAR, 1'b0, HOLD_CLEAR);
            end
            default:
            begin
                // unused codes leave no trace
            end
        endcase
        if (pin_beats_due.size() > first)
        begin
            tail = pin_beats_due.pop_back();
            tail.last = 1'b1;
            pin_beats_due.push_back(tail);
        end
    endfunction

    function automatic void check_beat(input logic rs, input logic [3:0] nibble,
                                       input logic strobe, input logic [11:0] hold,
                                       input logic last);
        pin_beat_t got;
        pin_beat_t want;
        got = '{rs: rs, nibble: nibble, strobe: strobe, hold: hold, last: last};
        if (pin_beats_due.size() == 0)
        begin
            error_count = error_count + 1;
            if (reported < REPORT_LIMIT)
            begin
                reported = reported + 1;
                $display("%0t: pin beat with nothing due: rs=%0d nib=%h en=%0d hold=%0d last=%0d",
                         $realtime, rs, nibble, strobe, hold, last);
            end
        end
        else
        begin
            want = pin_beats_due.pop_front();
            if (want !== got)
            begin
                error_count = error_count + 1;
                if (reported < REPORT_LIMIT)
                begin
                    reported = reported + 1;
                    $display("%0t: pin beat mismatch, want rs=%0d nib=%h en=%0d hold=%0d last=%0d",
                             $realtime, want.rs, want.nibble, want.strobe, want.hold, want.last);
                    $display("%0t:                      got  rs=%0d nib=%h en=%0d hold=%0d last=%0d",
                             $realtime, got.rs, got.nibble, got.strobe, got.hold, got.last);
                end
            end
        end
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pin_beats_due.delete();
            column_count = COLUMN_RESET;
            line_count   = LINE_RESET;
            display_ctrl = CTRL_RESET;
            entry_mode   = ENTRY_RESET;
            message_row  = 3'd0;
            error_count  = 0;
            reported     = 0;
            pending      = 0;
        end
        else
        begin
            if (cfg_wen)
            begin
                if (cfg_index == COLUMN_REG)
                    column_count = cfg_data;
                else if (cfg_index == LINE_REG)
                    line_count = cfg_data[2:0];
            end
            if (s_tvalid && s_tready)
                predict_request(s_tuser, s_tdata);
            if (m_tvalid && m_tready)
                check_beat(m_tuser, m_tdata[3:0], m_tdata[4], m_tdata[16:5], m_tlast);
            pending = pin_beats_due.size();
        end
    end

endmodule

@@ verif/char_lcd_nibble_sequencer_top_test.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// char_lcd_nibble_sequencer_top_test
// drives directed and random lcd requests under several geometries and
// back-pressure mixes; the checker beside the block judges every pin beat
// ----------------------------------------------------------------------------

module char_lcd_nibble_sequencer_top_test;

    import lcdns_pkg::*;

    localparam logic       REG_COLUMN_COUNT = 1'b0;
    localparam logic       REG_LINE_COUNT   = 1'b1;
    localparam logic [3:0] REQ_UNUSED_LO    = 4'd12;
    localparam logic [3:0] REQ_UNUSED_HI    = 4'd15;
    localparam int         RANDOM_BLOCKS    = 6;
    localparam int         ITEMS_PER_BLOCK  = 80;
    localparam int         SETTLE_CYCLES    = 20;

    logic        clk       = 1'b0;
    logic        rst_n     = 1'b0;
    logic        cfg_wen   = 1'b0;
    logic        cfg_index = 1'b0;
    logic [5:0]  cfg_data  = 6'd0;
    logic        s_tvalid  = 1'b0;
    logic        s_tready;
    logic [23:0] s_tdata   = 24'd0;
    logic [3:0]  s_tuser   = 4'd0;
    logic        m_tvalid;
    logic        m_tready  = 1'b0;
    logic [23:0] m_tdata;
    logic        m_tuser;
    logic        m_tlast;
    int          error_count;
    int          pending;
    int          send_idle_pct = 27;
    int          recv_idle_pct = 73;

    always #5 clk = ~clk;

    char_lcd_nibble_sequencer_top DUT (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_wen   (cfg_wen),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .m_tlast   (m_tlast)
    );

    char_lcd_nibble_sequencer_checker #(
        .COLUMN_REG (REG_COLUMN_COUNT),
        .LINE_REG   (REG_LINE_COUNT)
    ) lcd_checker (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_wen     (cfg_wen),
        .cfg_index   (cfg_index),
        .cfg_data    (cfg_data),
        .s_tvalid    (s_tvalid),
        .s_tready    (s_tready),
        .s_tdata     (s_tdata),
        .s_tuser     (s_tuser),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .m_tdata     (m_tdata),
        .m_tuser     (m_tuser),
        .m_tlast     (m_tlast),
        .error_count (error_count),
        .pending     (pending)
    );

    // pin side back-pressure
    always @(negedge clk)
        m_tready <= ($urandom_range(0, 99) >= recv_idle_pct);

    function automatic logic [23:0] pack_request(input logic [7:0] value, input logic [5:0] col,
                                                 input logic [2:0] row, input logic flag,
                                                 input logic start);
        return {5'd0, start, flag, row, col, value};
    endfunction

    // called and returns at a falling edge; tvalid is held high from the request until it is taken
    task automatic send_request(input logic [3:0] req, input logic [23:0] fields);
        while ($urandom_range(0, 99) < send_idle_pct)
        begin
            s_tvalid <= 1'b0;
            s_tuser  <= 4'($urandom);
            s_tdata  <= {5'd0, 19'($urandom)};
            @(negedge clk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= req;
        s_tdata  <= fields;
        do
            @(posedge clk);
        while (!s_tready);
        @(negedge clk);
    endtask

    task automatic hold_until_drained();
        s_tvalid <= 1'b0;
        @(negedge clk);
        while (pending != 0)
            @(negedge clk);
    endtask

    // registers change only once the block has gone quiet
    task automatic set_geometry(input logic [5:0] cols, input logic [2:0] lines);
        hold_until_drained();
        repeat (SETTLE_CYCLES) @(negedge clk);
        cfg_wen   <= 1'b1;
        cfg_index <= REG_COLUMN_COUNT;
        cfg_data  <= cols;
        @(negedge clk);
        cfg_index <= REG_LINE_COUNT;
        cfg_data  <= {3'd0, lines};
        @(negedge clk);
        cfg_wen   <= 1'b0;
        @(negedge clk);
    endtask

    // a message opens with message_start, then characters and newlines, now and then with message_start again
    task automatic send_message(inout int sent);
        int         length;
        int         newline_pct;
        logic [7:0] ch;
        logic       start;
        length      = $urandom_range(1, 16);
        newline_pct = $urandom_range(0, 1) ? 60 : 10;
        for (int i = 0; i < length; i++)
        begin
            ch    = ($urandom_range(0, 99) < newline_pct) ? CHAR_NEWLINE : 8'($urandom);
            start = (i == 0) ? 1'b1 : ($urandom_range(0, 19) == 0);
            send_request(REQ_MSG, pack_request(ch, 6'($urandom), 3'($urandom),
                                               1'($urandom), start));
        end
        sent += length;
    endtask

    task automatic send_single(inout int sent);
        int         pick;
        logic [3:0] req;
        pick = $urandom_range(0, 99);
        if (pick < 5)
            req = REQ_INIT;
        else if (pick < 10)
            req = 4'($urandom_range(REQ_UNUSED_LO, REQ_UNUSED_HI));
        else
            req = 4'($urandom_range(REQ_CMD, REQ_HOME));
        send_request(req, pack_request(8'($urandom), 6'($urandom), 3'($urandom),
                                       1'($urandom), 1'($urandom)));
        if (req < REQ_UNUSED_LO)
            sent += 1;
    endtask

    task automatic run_directed();
        send_request(REQ_INIT,        pack_request(8'h00, 6'd0,  3'd0, 1'b0, 1'b0));
        send_request(REQ_CMD,         pack_request(8'h00, 6'd0,  3'd0, 1'b0, 1'b0));
        send_request(REQ_CMD,         pack_request(8'hFF, 6'd63, 3'd7, 1'b1, 1'b1));
        send_request(REQ_MSG,         pack_request(8'h41, 6'd0,  3'd0, 1'b0, 1'b1));
        send_request(REQ_MSG,         pack_request(8'hFF, 6'd0,  3'd0, 1'b0, 1'b0));
        send_request(REQ_MSG,         pack_request(CHAR_NEWLINE, 6'd0, 3'd0, 1'b0, 1'b0));
        send_request(REQ_MSG,         pack_request(CHAR_NEWLINE, 6'd0, 3'd0, 1'b0, 1'b1));
        send_request(REQ_CURSOR,      pack_request(8'h00, 6'd0,  3'd0, 1'b0, 1'b0));
        // row clamp together with address wrap
        send_request(REQ_CURSOR,      pack_request(8'h00, 6'd63, 3'd7, 1'b0, 1'b0));
        send_request(REQ_CURSOR,      pack_request(8'h00, 6'd39, 3'd3, 1'b0, 1'b0));
        send_request(REQ_CURSOR,      pack_request(8'h00, 6'd5,  3'd1, 1'b0, 1'b0));
        send_request(REQ_DISPLAY,     pack_request(8'h00, 6'd0,  3'd0, 1'b0, 1'b0));
        send_request(REQ_DISPLAY,     pack_request(8'h00, 6'd0,  3'd0, 1'b1, 1'b0));
        send_request(REQ_CURSOR_SHOW, pack_request(8'h00, 6'd0,  3'd0, 1'b1, 1'b0));
        send_request(REQ_BLINK,       pack_request(8'h00, 6'd0,  3'd0, 1'b1, 1'b0));
        send_request(REQ_BLINK,       pack_request(8'h00, 6'd0,  3'd0, 1'b0, 1'b0));
        send_request(REQ_CURSOR_SHOW, pack_request(8'h00, 6'd0,  3'd0, 1'b0, 1'b0));
        send_request(REQ_SHIFT,       pack_request(8'h00, 6'd0,  3'd0, 1'b0, 1'b0));
        send_request(REQ_SHIFT,       pack_request(8'h00, 6'd0,  3'd0, 1'b1, 1'b0));
        send_request(REQ_LTR,         pack_request(8'h00, 6'd0,  3'd0, 1'b0, 1'b0));
        send_request(REQ_AUTOSCROLL,  pack_request(8'h00, 6'd0,  3'd0, 1'b1, 1'b0));
        send_request(REQ_AUTOSCROLL,  pack_request(8'h00, 6'd0,  3'd0, 1'b0, 1'b0));
        send_request(REQ_CLEAR,       pack_request(8'h00, 6'd0,  3'd0, 1'b0, 1'b0));
        send_request(REQ_HOME,        pack_request(8'h00, 6'd0,  3'd0, 1'b0, 1'b0));
        send_request(REQ_UNUSED_LO,   pack_request(8'hFF, 6'd63, 3'd7, 1'b1, 1'b1));
        send_request(REQ_UNUSED_HI,   pack_request(8'h00, 6'd0,  3'd0, 1'b0, 1'b0));
    endtask

    initial
    begin
        int         sent;
        bit         paused;
        logic [5:0] cols;
        logic [2:0] lines;
        repeat (4) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        run_directed();

        for (int blk = 0; blk < RANDOM_BLOCKS; blk++)
        begin
            // include zero and over-range geometry
            case (blk)
                0:       begin cols = 6'd40; lines = 3'd2; end
                1:       begin cols = 6'd1;  lines = 3'd1; end
                2:       begin cols = 6'd0;  lines = 3'd0; end
                3:       begin cols = 6'd63; lines = 3'd7; end
                4:       begin cols = 6'd7;  lines = 3'd3; end
                default: begin cols = 6'd20; lines = 3'd4; end
            endcase
            set_geometry(cols, lines);
            if (blk < 2)
            begin
                send_idle_pct = 27;
                recv_idle_pct = 73;
            end
            else if (blk < 4)
            begin
                send_idle_pct = 73;
                recv_idle_pct = 27;
            end
            else
            begin
                send_idle_pct = 0;
                recv_idle_pct = 0;
            end
            sent   = 0;
            paused = 1'b0;
            while (sent < ITEMS_PER_BLOCK)
            begin
                if (!paused && sent >= ITEMS_PER_BLOCK / 2)
                begin
                    hold_until_drained();
                    paused = 1'b1;
                end
                if ($urandom_range(0, 99) < 40)
                    send_message(sent);
                else
                    send_single(sent);
            end
        end

        hold_until_drained();
        repeat (SETTLE_CYCLES) @(posedge clk);
        if (error_count == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end

    initial
    begin
        #(50_000_000);
        $display("Verification failed");
        $finish;
    end

endmodule

@@ files.f @@
+incdir+sv
sv/lcdns_pkg.sv
sv/lcdns_front.sv
sv/lcdns_fifo.sv
sv/lcdns_back.sv
sv/char_lcd_nibble_sequencer_top.sv
verif/char_lcd_nibble_sequencer_checker.sv
verif/char_lcd_nibble_sequencer_top_test.sv
